// ----- hdl/wavp_pkg.sv -----
package wavp_pkg;

  // chunk tags as they read when shifted in, first byte in the top octet
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [31:0] FMT_MAX_BYTES = 32'd4096;
  localparam logic [31:0] BITS_LO_POS   = 32'd14;
  localparam logic [31:0] BITS_HI_POS   = 32'd15;
  localparam logic [31:0] TAG_BYTES     = 32'd4;
  localparam logic [31:0] HEADER_BYTES  = 32'd12;

  localparam logic [15:0] FMT_CODE_PCM  = 16'd1;
  localparam logic [15:0] CHAN_MONO     = 16'd1;
  localparam logic [15:0] BITS_16       = 16'd16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;
  localparam int RATE_W     = 18;
  localparam int MAX_BYTES_W = 27;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_BYTES = 2'd1;
  localparam logic [RATE_W-1:0]      RATE_RESET      = 18'd16000;
  localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 27'd67108864;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
  localparam logic [2:0] ST_TRUNC     = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_BAD_DATA  = 3'd4;
  localparam logic [2:0] ST_MISSING   = 3'd5;
  localparam logic [2:0] ST_WRONG_FMT = 3'd6;
  localparam logic [2:0] ST_ODD_COUNT = 3'd7;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef enum logic [7:0] {
    PH_HEADER = 8'b0000_0001,
    PH_ID     = 8'b0000_0010,
    PH_SIZE   = 8'b0000_0100,
    PH_FMT    = 8'b0000_1000,
    PH_SKIP   = 8'b0001_0000,
    PH_PAD    = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               is_sample;
    logic [2:0]         status_code;
    logic               file_done;
  } res_t;

  // up to two results per item, the second only together with the first
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } res_push_t;

endpackage

// ----- hdl/wavp_if.sv -----
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_marker;
  modport source (output valid, output file_byte, output end_marker, input ready);
  modport sink   (input valid, input file_byte, input end_marker, output ready);
endinterface

interface wavp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               is_sample;
  logic [2:0]         status_code;
  logic               file_done;
  modport source (output valid, output pcm_sample, output is_sample,
                  output status_code, output file_done, input ready);
  modport sink   (input valid, input pcm_sample, input is_sample,
                  input status_code, input file_done, output ready);
endinterface

interface wavp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wavp_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [wavp_pkg::CFG_DATA_W-1:0]  wr_data;
  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- hdl/wavp_res_fifo.sv -----
module wavp_res_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  wavp_pkg::res_push_t push,
  output logic                room_two,
  wavp_out_if.source          out_ch
);
  import wavp_pkg::*;

  res_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_ptr_p1;

  assign pop       = out_ch.valid && out_ch.ready;
  assign wr_ptr_p1 = wr_ptr_r + RES_PTR_W'(1);
  // two free slots, whatever the sink does this cycle
  assign room_two  = cnt_r <= RES_CNT_W'(RES_DEPTH - 2);

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.pcm_sample  = mem_r[rd_ptr_r].pcm_sample;
  assign out_ch.is_sample   = mem_r[rd_ptr_r].is_sample;
  assign out_ch.status_code = mem_r[rd_ptr_r].status_code;
  assign out_ch.file_done   = mem_r[rd_ptr_r].file_done;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.v0) + RES_PTR_W'(push.v1);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(push.v0) + RES_CNT_W'(push.v1) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/wav_pcm16_mono_stream_parser_top.sv -----
// WAV stream parser for 16-bit mono PCM. The file enters one byte per item
// on in_ch, closed by an item with end_marker set (its byte is ignored). The
// parser checks the RIFF/WAVE header, walks the chunks, captures the fmt
// fields, skips unknown chunks and pad bytes, and at the data chunk streams
// the little-endian samples out as signed Q1.15 (raw sample bits), followed
// by one status item with file_done set: 0 ok, 1 bad RIFF/WAVE, 2 truncated,
// 3 bad fmt size, 4 bad data size, 5 missing chunk, 6 wrong format, 7 odd
// byte count. Samples only flow when the data verdict is ok. A header error
// is reported on the byte that reveals it; after a status the remaining
// bytes are dropped until the end marker, which then rearms silently. An end
// marker before any status yields status 5 on a chunk boundary, otherwise 2.
// Rate: one byte per clock. The whole parse step for a byte is combinational
// logic behind the state registers (a 32-bit position increment
// and compare set the path). Results go through a four-entry queue; the
// last data byte can yield a sample and the status together, and in_ready
// drops while fewer than two queue slots are free, i.e. only when the sink
// stalls. Results leave at one per cycle. Configuration (register 0:
// expected sample rate, 1: largest data chunk in bytes) is always ready and
// is to be written between files; other indices are ignored.
module wav_pcm16_mono_stream_parser_top (
  input logic        clk,
  input logic        rst_n,
  wavp_in_if.sink    in_ch,
  wavp_out_if.source out_ch,
  wavp_cfg_if.sink   cfg_ch
);
  import wavp_pkg::*;

  // configuration registers
  logic [RATE_W-1:0]      exp_rate_r;
  logic [MAX_BYTES_W-1:0] max_bytes_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [15:0] fmt_code_r, fmt_code_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [2:0]  pend_r, pend_nxt;

  logic        in_acc;
  logic        room_two;
  logic [31:0] pos_inc;
  logic [31:0] tag_shift;
  logic [31:0] byte_lane;
  logic [31:0] len_new;
  logic        fmt_ok;
  logic        sample_v, stat_v;
  logic [2:0]  stat_code;
  res_t        sample_res, stat_res;
  res_push_t   push;

  assign in_ch.ready  = room_two;
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign pos_inc   = pos_r + 32'd1;
  assign tag_shift = {tag_r[23:0], in_ch.file_byte};
  // the byte placed at little-endian lane pos[1:0]
  assign byte_lane = {24'd0, in_ch.file_byte} << {pos_r[1:0], 3'b000};
  assign len_new   = len_r | byte_lane;

  assign fmt_ok = (fmt_code_r == FMT_CODE_PCM) && (chan_r == CHAN_MONO) &&
                  (rate_r == {14'd0, exp_rate_r}) && (bits_r == BITS_16);

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    tag_nxt      = tag_r;
    fmt_code_nxt = fmt_code_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    fmt_seen_nxt = fmt_seen_r;
    low_nxt      = low_r;
    pend_nxt     = pend_r;
    sample_v     = 1'b0;
    stat_v       = 1'b0;
    stat_code    = ST_OK;

    if (in_acc) begin
      if (in_ch.end_marker) begin
        // end of file: report if no status went out yet, then rearm
        if (phase_r != PH_DONE) begin
          stat_v    = 1'b1;
          stat_code = (phase_r == PH_ID && pos_r == '0) ? ST_MISSING : ST_TRUNC;
        end
        phase_nxt    = PH_HEADER;
        pos_nxt      = '0;
        len_nxt      = '0;
        tag_nxt      = '0;
        fmt_code_nxt = '0;
        chan_nxt     = '0;
        rate_nxt     = '0;
        bits_nxt     = '0;
        fmt_seen_nxt = 1'b0;
        low_nxt      = '0;
        pend_nxt     = ST_OK;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            tag_nxt = tag_shift;
            pos_nxt = pos_inc;
            if (pos_inc == TAG_BYTES) begin
              len_nxt = tag_shift;
            end
            // len_r holds the first tag once four bytes are in
            if (pos_inc == HEADER_BYTES) begin
              if (len_r != TAG_RIFF || tag_shift != TAG_WAVE) begin
                stat_v    = 1'b1;
                stat_code = ST_BAD_RIFF;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_ID;
                pos_nxt   = '0;
                len_nxt   = '0;
              end
            end
          end
          PH_ID: begin
            tag_nxt = tag_shift;
            pos_nxt = pos_inc;
            if (pos_inc == TAG_BYTES) begin
              phase_nxt = PH_SIZE;
              pos_nxt   = '0;
              len_nxt   = '0;
            end
          end
          PH_SIZE: begin
            len_nxt = len_new;
            pos_nxt = pos_inc;
            if (pos_inc == TAG_BYTES) begin
              pos_nxt = '0;
              if (tag_r == TAG_FMT) begin
                if (len_new < FMT_MIN_BYTES || len_new > FMT_MAX_BYTES) begin
                  stat_v    = 1'b1;
                  stat_code = ST_BAD_FMT;
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_FMT;
                end
              end else if (tag_r == TAG_DATA) begin
                if (len_new == '0 || len_new > {5'd0, max_bytes_r}) begin
                  stat_v    = 1'b1;
                  stat_code = ST_BAD_DATA;
                  phase_nxt = PH_DONE;
                end else begin
                  // verdict fixed here, reported with the last data byte
                  if (!fmt_seen_r) begin
                    pend_nxt = ST_MISSING;
                  end else if (!fmt_ok) begin
                    pend_nxt = ST_WRONG_FMT;
                  end else if (len_new[0]) begin
                    pend_nxt = ST_ODD_COUNT;
                  end else begin
                    pend_nxt = ST_OK;
                  end
                  phase_nxt = PH_DATA;
                end
              end else begin
                phase_nxt = (len_new == '0) ? PH_ID : PH_SKIP;
              end
            end
          end
          PH_FMT: begin
            if (pos_r == '0) begin
              fmt_code_nxt = {8'd0, in_ch.file_byte};
              chan_nxt     = '0;
              rate_nxt     = '0;
              bits_nxt     = '0;
            end else if (pos_r < 32'd2) begin
              fmt_code_nxt = fmt_code_r | byte_lane[15:0];
            end else if (pos_r < 32'd4) begin
              chan_nxt = chan_r | (byte_lane[15:0] | byte_lane[31:16]);
            end else if (pos_r < 32'd8) begin
              rate_nxt = rate_r | byte_lane;
            end else if (pos_r == BITS_LO_POS || pos_r == BITS_HI_POS) begin
              bits_nxt = bits_r | (byte_lane[15:0] | byte_lane[31:16]);
            end
            pos_nxt = pos_inc;
            if (pos_inc == len_r) begin
              fmt_seen_nxt = 1'b1;
              phase_nxt    = len_r[0] ? PH_PAD : PH_ID;
              pos_nxt      = '0;
            end
          end
          PH_SKIP: begin
            pos_nxt = pos_inc;
            if (pos_inc == len_r) begin
              phase_nxt = len_r[0] ? PH_PAD : PH_ID;
              pos_nxt   = '0;
            end
          end
          PH_PAD: begin
            phase_nxt = PH_ID;
            pos_nxt   = '0;
          end
          PH_DATA: begin
            if (!pos_r[0]) begin
              low_nxt = in_ch.file_byte;
            end else if (pend_r == ST_OK) begin
              sample_v = 1'b1;
            end
            pos_nxt = pos_inc;
            if (pos_inc == len_r) begin
              stat_v    = 1'b1;
              stat_code = pend_r;
              phase_nxt = PH_DONE;
            end
          end
          PH_DONE: begin
            // bytes dropped until the end marker
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase
      end
    end
  end

  // results of this item, sample first when both come
  always_comb begin
    sample_res.pcm_sample  = {in_ch.file_byte, low_r};
    sample_res.is_sample   = 1'b1;
    sample_res.status_code = ST_OK;
    sample_res.file_done   = 1'b0;
    stat_res.pcm_sample    = '0;
    stat_res.is_sample     = 1'b0;
    stat_res.status_code   = stat_code;
    stat_res.file_done     = 1'b1;
    push.v0 = sample_v || stat_v;
    push.v1 = sample_v && stat_v;
    push.r0 = sample_v ? sample_res : stat_res;
    push.r1 = stat_res;
  end

  wavp_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room_two (room_two),
    .out_ch   (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_rate_r  <= RATE_RESET;
      max_bytes_r <= MAX_BYTES_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.reg_index == CFG_IDX_RATE) begin
        exp_rate_r <= cfg_ch.wr_data[RATE_W-1:0];
      end else if (cfg_ch.reg_index == CFG_IDX_MAX_BYTES) begin
        max_bytes_r <= cfg_ch.wr_data[MAX_BYTES_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      len_r      <= '0;
      tag_r      <= '0;
      fmt_code_r <= '0;
      chan_r     <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      fmt_seen_r <= 1'b0;
      low_r      <= '0;
      pend_r     <= ST_OK;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      tag_r      <= tag_nxt;
      fmt_code_r <= fmt_code_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      low_r      <= low_nxt;
      pend_r     <= pend_nxt;
    end
  end

  // an end marker always leaves the parser rearmed
  a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.end_marker |=> phase_r == PH_HEADER && !fmt_seen_r)
    else $error("parser not rearmed after end marker");

  // an ok data verdict needs a complete fmt chunk before it
  a_ok_needs_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA && pend_r == ST_OK |-> fmt_seen_r)
    else $error("ok data verdict without fmt chunk");

  // a status result moves the parser into the done phase or rearms it
  a_status_ends_file: assert property (@(posedge clk) disable iff (!rst_n)
    stat_v |=> phase_r == PH_DONE || phase_r == PH_HEADER)
    else $error("status issued but parsing continues");

  // samples never carry the file-done flag or a status
  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_sample |-> !out_ch.file_done && out_ch.status_code == ST_OK)
    else $error("sample result carries status");

endmodule
